// ----- hw/rtl/rpa_pkg.sv -----
package rpa_pkg;

  localparam int ADDR_W      = 34;
  localparam int ACTION_W    = 3;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 16;
  localparam int CFG_IDX_W   = 1;

  localparam int PAGE_COUNT_DEF  = 32768;
  localparam int PAGE_SHIFT_DEF  = 12;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic [ADDR_W-1:0] BASE_RESET = 34'h0_8004_9000;
  localparam logic [ADDR_W-1:0] TOP_RESET  = 34'h0_8800_0000;

  // depth of the queue between classification and execution
  localparam int Q_DEPTH = 2;

  localparam logic [ACTION_W-1:0] ACT_ALLOC = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_INC   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DEC   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_GET   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_BAD   = 3'd2,
    ST_ZERO  = 3'd3,
    ST_SAT   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    K_ALLOC = 3'd0,
    K_FREE  = 3'd1,
    K_INC   = 3'd2,
    K_DEC   = 3'd3,
    K_GET   = 3'd4,
    K_BAD   = 3'd5,
    K_NOP   = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  aligned;
  } item_ctl_t;

endpackage

// ----- hw/rtl/rpa_front.sv -----
module rpa_front #(
  parameter int PAGE_COUNT = rpa_pkg::PAGE_COUNT_DEF,
  parameter int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF,
  localparam int IDXW = $clog2(PAGE_COUNT),
  localparam int NW   = $clog2(PAGE_COUNT + 1)
) (
  input  logic [rpa_pkg::ACTION_W-1:0] action,
  input  logic [rpa_pkg::ADDR_W-1:0]   page_address,
  input  logic [rpa_pkg::ADDR_W-1:0]   area_lo,
  input  logic [NW-1:0]                area_pages,
  output rpa_pkg::item_ctl_t           ctl,
  output logic [IDXW-1:0]              idx
);

  logic [rpa_pkg::ADDR_W-1:0] diff;
  logic [rpa_pkg::ADDR_W-1:0] pg;
  logic                       in_range;
  logic                       aligned;

  assign diff     = page_address - area_lo;
  assign pg       = diff >> PAGE_SHIFT;
  assign in_range = (page_address >= area_lo) && (pg < rpa_pkg::ADDR_W'(area_pages));
  assign aligned  = (page_address[PAGE_SHIFT-1:0] == '0);
  assign idx      = pg[IDXW-1:0];

  always_comb begin
    ctl.aligned = aligned;
    case (action)
      rpa_pkg::ACT_ALLOC: ctl.kind = rpa_pkg::K_ALLOC;
      rpa_pkg::ACT_FREE:  ctl.kind = (in_range && aligned) ? rpa_pkg::K_FREE : rpa_pkg::K_BAD;
      rpa_pkg::ACT_INC:   ctl.kind = in_range ? rpa_pkg::K_INC : rpa_pkg::K_BAD;
      rpa_pkg::ACT_DEC:   ctl.kind = in_range ? rpa_pkg::K_DEC : rpa_pkg::K_BAD;
      rpa_pkg::ACT_GET:   ctl.kind = in_range ? rpa_pkg::K_GET : rpa_pkg::K_BAD;
      default:            ctl.kind = rpa_pkg::K_NOP;
    endcase
  end

endmodule

// ----- hw/rtl/rpa_queue.sv -----
module rpa_queue #(
  parameter int IW = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rpa_pkg::item_ctl_t push_ctl,
  input  logic [IW-1:0]      push_idx,
  input  logic               pop,
  output logic               full,
  output logic               empty,
  output rpa_pkg::item_ctl_t head_ctl,
  output logic [IW-1:0]      head_idx
);

  localparam int PW = (rpa_pkg::Q_DEPTH > 1) ? $clog2(rpa_pkg::Q_DEPTH) : 1;
  localparam int CW = $clog2(rpa_pkg::Q_DEPTH + 1);

  rpa_pkg::item_ctl_t mem_ctl [rpa_pkg::Q_DEPTH];
  logic [IW-1:0]      mem_idx [rpa_pkg::Q_DEPTH];

  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full     = (cnt_r == CW'(rpa_pkg::Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_ctl = mem_ctl[rd_ptr_r];
  assign head_idx = mem_idx[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_ctl[wr_ptr_r] <= push_ctl;
      mem_idx[wr_ptr_r] <= push_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(rpa_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(rpa_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/rpa_back.sv -----
module rpa_back #(
  parameter int PAGE_COUNT  = rpa_pkg::PAGE_COUNT_DEF,
  parameter int PAGE_SHIFT  = rpa_pkg::PAGE_SHIFT_DEF,
  parameter int COUNT_WIDTH = rpa_pkg::COUNT_WIDTH_DEF,
  localparam int IDXW = $clog2(PAGE_COUNT),
  localparam int NW   = $clog2(PAGE_COUNT + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rebuild,
  input  logic [rpa_pkg::ADDR_W-1:0]    area_lo,
  input  logic [NW-1:0]                 area_pages,
  input  logic                          q_empty,
  input  rpa_pkg::item_ctl_t            q_ctl,
  input  logic [IDXW-1:0]               q_idx,
  output logic                          q_pop,
  output logic                          clearing,
  output logic                          out_valid,
  output logic [rpa_pkg::ADDR_W-1:0]    out_alloc_address,
  output logic [rpa_pkg::COUNT_OUT_W-1:0] out_ref_count,
  output logic                          out_page_freed,
  output logic [rpa_pkg::STATUS_W-1:0]  out_status
);

  typedef enum logic [3:0] {
    BS_INIT = 4'b0001,
    BS_CLR  = 4'b0010,
    BS_IDLE = 4'b0100,
    BS_EXEC = 4'b1000
  } bstate_t;

  // next_free entry: {valid, next index}
  logic [IDXW:0]        nf_mem [PAGE_COUNT];
  logic [COUNT_WIDTH-1:0] rc_mem [PAGE_COUNT];

  bstate_t              state_r, state_nxt;
  logic [NW-1:0]        clr_r;
  logic [IDXW-1:0]      head_r, head_nxt;
  logic                 head_valid_r, head_valid_nxt;
  rpa_pkg::item_ctl_t   cur_ctl_r;
  logic [IDXW-1:0]      cur_idx_r;
  logic [IDXW:0]        nf_rd_r;
  logic [COUNT_WIDTH-1:0] rc_rd_r;

  logic                 out_valid_r;
  logic [rpa_pkg::ADDR_W-1:0] out_addr_r;
  logic [rpa_pkg::COUNT_OUT_W-1:0] out_cnt_r;
  logic                 out_freed_r;
  rpa_pkg::status_t     out_status_r;

  logic [IDXW-1:0]      rd_idx;
  logic                 nf_we, rc_we;
  logic [IDXW-1:0]      nf_wa, rc_wa;
  logic [IDXW:0]        nf_wd;
  logic [COUNT_WIDTH-1:0] rc_wd;
  logic                 clr_done;

  logic [rpa_pkg::ADDR_W-1:0] res_addr;
  logic [COUNT_WIDTH-1:0] res_cnt;
  logic                 res_freed;
  rpa_pkg::status_t     res_status;
  logic [COUNT_WIDTH-1:0] rc_dec;

  assign clearing = (state_r == BS_INIT) || (state_r == BS_CLR);
  assign clr_done = (clr_r == area_pages);
  assign q_pop    = (state_r == BS_IDLE) && !q_empty;
  assign rd_idx   = (q_ctl.kind == rpa_pkg::K_ALLOC) ? head_r : q_idx;
  assign rc_dec   = rc_rd_r - 1'b1;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    head_valid_nxt = head_valid_r;
    nf_we          = 1'b0;
    nf_wa          = cur_idx_r;
    nf_wd          = {head_valid_r, head_r};
    rc_we          = 1'b0;
    rc_wa          = cur_idx_r;
    rc_wd          = '0;
    res_addr       = '0;
    res_cnt        = '0;
    res_freed      = 1'b0;
    res_status     = rpa_pkg::ST_OK;
    case (state_r)
      BS_INIT: state_nxt = BS_CLR;
      BS_CLR: begin
        if (clr_done) begin
          head_nxt       = IDXW'(area_pages - 1'b1);
          head_valid_nxt = (area_pages != '0);
          state_nxt      = BS_IDLE;
        end else begin
          // entry i links to i-1; entry zero ends the list
          nf_we = 1'b1;
          nf_wa = clr_r[IDXW-1:0];
          nf_wd = {(clr_r != '0), IDXW'(clr_r - 1'b1)};
          rc_we = 1'b1;
          rc_wa = clr_r[IDXW-1:0];
          rc_wd = '0;
        end
      end
      BS_IDLE: begin
        if (q_pop) begin
          state_nxt = BS_EXEC;
        end
      end
      BS_EXEC: begin
        state_nxt = BS_IDLE;
        case (cur_ctl_r.kind)
          rpa_pkg::K_ALLOC: begin
            if (head_valid_r) begin
              head_nxt       = nf_rd_r[IDXW-1:0];
              head_valid_nxt = nf_rd_r[IDXW];
              rc_we          = 1'b1;
              rc_wd          = COUNT_WIDTH'(1);
              res_addr       = area_lo + (rpa_pkg::ADDR_W'(cur_idx_r) << PAGE_SHIFT);
              res_cnt        = COUNT_WIDTH'(1);
            end else begin
              res_status = rpa_pkg::ST_EMPTY;
            end
          end
          rpa_pkg::K_FREE: begin
            nf_we          = 1'b1;
            head_nxt       = cur_idx_r;
            head_valid_nxt = 1'b1;
            res_freed      = 1'b1;
            res_cnt        = rc_rd_r;
          end
          rpa_pkg::K_INC: begin
            if (rc_rd_r == '1) begin
              res_status = rpa_pkg::ST_SAT;
              res_cnt    = rc_rd_r;
            end else begin
              rc_we   = 1'b1;
              rc_wd   = rc_rd_r + 1'b1;
              res_cnt = rc_rd_r + 1'b1;
            end
          end
          rpa_pkg::K_DEC: begin
            if (rc_rd_r == '0) begin
              res_status = rpa_pkg::ST_ZERO;
            end else begin
              rc_we   = 1'b1;
              rc_wd   = rc_dec;
              res_cnt = rc_dec;
              if (rc_dec == '0) begin
                if (cur_ctl_r.aligned) begin
                  nf_we          = 1'b1;
                  head_nxt       = cur_idx_r;
                  head_valid_nxt = 1'b1;
                  res_freed      = 1'b1;
                end else begin
                  res_status = rpa_pkg::ST_BAD;
                end
              end
            end
          end
          rpa_pkg::K_GET: res_cnt = rc_rd_r;
          rpa_pkg::K_BAD: res_status = rpa_pkg::ST_BAD;
          default: ;
        endcase
      end
      default: state_nxt = BS_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nf_we) begin
      nf_mem[nf_wa] <= nf_wd;
    end
    if (q_pop) begin
      nf_rd_r <= nf_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rc_we) begin
      rc_mem[rc_wa] <= rc_wd;
    end
    if (q_pop) begin
      rc_rd_r <= rc_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BS_INIT;
      clr_r        <= '0;
      head_r       <= '0;
      head_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (rebuild) begin
      state_r      <= BS_INIT;
      head_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      head_valid_r <= head_valid_nxt;
      out_valid_r  <= (state_r == BS_EXEC);
      if (state_r == BS_INIT) begin
        clr_r <= '0;
      end else if ((state_r == BS_CLR) && !clr_done) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_ctl_r <= q_ctl;
      cur_idx_r <= rd_idx;
    end
    if (state_r == BS_EXEC) begin
      out_addr_r   <= res_addr;
      out_cnt_r    <= rpa_pkg::COUNT_OUT_W'(res_cnt);
      out_freed_r  <= res_freed;
      out_status_r <= res_status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_alloc_address = out_addr_r;
  assign out_ref_count     = out_cnt_r;
  assign out_page_freed    = out_freed_r;
  assign out_status        = out_status_r;

endmodule

// ----- hw/rtl/refcounted_page_allocator.sv -----
// Page allocator with a last-in first-out free list and a reference count per page. An action
// is taken when start is high and busy is low; its result shows on the out_ ports for exactly
// one cycle with out_valid high, and the receiver cannot hold it off. An accepted action goes
// into the queue, is popped into the execution state and has its result registered on the out_
// ports. The execution side takes no new action before it is through with the last: each one
// reads its table entry and the free-list head, then writes them back before the next read may
// start. A two-entry queue takes actions ahead of execution, so busy stays low until it fills.
// After reset and after every configuration write the tables are swept, one page a cycle, and
// busy is high during the sweep; cfg_ready is always high.
module refcounted_page_allocator #(
  parameter int PAGE_COUNT  = rpa_pkg::PAGE_COUNT_DEF,
  parameter int PAGE_SHIFT  = rpa_pkg::PAGE_SHIFT_DEF,
  parameter int COUNT_WIDTH = rpa_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [rpa_pkg::ACTION_W-1:0]    in_action,
  input  logic [rpa_pkg::ADDR_W-1:0]      in_page_address,
  output logic                            out_valid,
  output logic [rpa_pkg::ADDR_W-1:0]      out_alloc_address,
  output logic [rpa_pkg::COUNT_OUT_W-1:0] out_ref_count,
  output logic                            out_page_freed,
  output logic [rpa_pkg::STATUS_W-1:0]    out_status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpa_pkg::ADDR_W-1:0]      cfg_data
);

  localparam int IDXW = $clog2(PAGE_COUNT);
  localparam int NW   = $clog2(PAGE_COUNT + 1);
  localparam logic [rpa_pkg::ADDR_W-1:0] OFF_MASK =
    rpa_pkg::ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);

  logic [rpa_pkg::ADDR_W-1:0] base_r, top_r;
  logic [rpa_pkg::ADDR_W-1:0] area_lo_r, area_lo_nxt;
  logic [NW-1:0]              area_pages_r, area_pages_nxt;
  logic [rpa_pkg::ADDR_W-1:0] area_hi, span;

  logic                 accept, rebuild;
  rpa_pkg::item_ctl_t   fr_ctl, q_ctl;
  logic [IDXW-1:0]      fr_idx, q_idx;
  logic                 q_full, q_empty, q_pop, clearing;

  assign cfg_ready = 1'b1;
  assign rebuild   = cfg_valid && cfg_ready;
  assign busy      = clearing || q_full;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= rpa_pkg::BASE_RESET;
      top_r  <= rpa_pkg::TOP_RESET;
    end else if (rebuild) begin
      case (cfg_index)
        rpa_pkg::REG_BASE: base_r <= cfg_data;
        rpa_pkg::REG_TOP:  top_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // managed page count: min(PAGE_COUNT, (top - base) >> PAGE_SHIFT), both page aligned; zero if top <= base
  assign area_lo_nxt = base_r & ~OFF_MASK;
  assign area_hi     = top_r & ~OFF_MASK;
  assign span        = (area_hi - area_lo_nxt) >> PAGE_SHIFT;

  always_comb begin
    if (area_hi <= area_lo_nxt) begin
      area_pages_nxt = '0;
    end else if (span > rpa_pkg::ADDR_W'(PAGE_COUNT)) begin
      area_pages_nxt = NW'(PAGE_COUNT);
    end else begin
      area_pages_nxt = NW'(span);
    end
  end

  always_ff @(posedge clk) begin
    area_lo_r    <= area_lo_nxt;
    area_pages_r <= area_pages_nxt;
  end

  rpa_front #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_front (
    .action       (in_action),
    .page_address (in_page_address),
    .area_lo      (area_lo_r),
    .area_pages   (area_pages_r),
    .ctl          (fr_ctl),
    .idx          (fr_idx)
  );

  rpa_queue #(
    .IW (IDXW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_ctl (fr_ctl),
    .push_idx (fr_idx),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_ctl (q_ctl),
    .head_idx (q_idx)
  );

  rpa_back #(
    .PAGE_COUNT  (PAGE_COUNT),
    .PAGE_SHIFT  (PAGE_SHIFT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .rebuild           (rebuild),
    .area_lo           (area_lo_r),
    .area_pages        (area_pages_r),
    .q_empty           (q_empty),
    .q_ctl             (q_ctl),
    .q_idx             (q_idx),
    .q_pop             (q_pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_alloc_address (out_alloc_address),
    .out_ref_count     (out_ref_count),
    .out_page_freed    (out_page_freed),
    .out_status        (out_status)
  );

  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on consecutive cycles");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> busy)
    else $error("not busy after configuration write");

  a_freed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_page_freed) |-> (out_status == rpa_pkg::ST_OK))
    else $error("page pushed with error status");

  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_alloc_address != '0)) |->
      ((out_ref_count == rpa_pkg::COUNT_OUT_W'(1)) && !out_page_freed))
    else $error("allocated page without count of one");

endmodule

// ----- tb/sv/tb_refcounted_page_allocator.sv -----
module tb_refcounted_page_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import rpa_pkg::*;

  localparam int SHIFT          = PAGE_SHIFT_DEF;
  localparam int NPAGES         = PAGE_COUNT_DEF;
  localparam int unsigned CMAX  = (1 << COUNT_WIDTH_DEF) - 1;
  localparam int IDLE_PCT       = 12;
  localparam int WINDOW         = 24;
  localparam int WATCHDOG_LIMIT = 150000;
  localparam int TAIL_CYCLES    = 20;
  localparam int SHOW_LIMIT     = 40;

  localparam logic [ADDR_W-1:0] OFFSET_MASK = ADDR_W'((64'd1 << SHIFT) - 1);
  localparam logic [ACTION_W-1:0] ACT_RSVD_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_RSVD_HI = 3'd7;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   addr;
  } page_cmd_t;

  typedef struct {
    logic [ADDR_W-1:0]      alloc_address;
    logic [COUNT_OUT_W-1:0] ref_count;
    logic                   page_freed;
    status_t                status;
  } page_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [ACTION_W-1:0]    in_action = ACT_ALLOC;
  logic [ADDR_W-1:0]      in_page_address = '0;
  logic                   out_valid;
  logic [ADDR_W-1:0]      out_alloc_address;
  logic [COUNT_OUT_W-1:0] out_ref_count;
  logic                   out_page_freed;
  logic [STATUS_W-1:0]    out_status;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_BASE;
  logic [ADDR_W-1:0]      cfg_data = '0;

  refcounted_page_allocator u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_page_address   (in_page_address),
    .out_valid         (out_valid),
    .out_alloc_address (out_alloc_address),
    .out_ref_count     (out_ref_count),
    .out_page_freed    (out_page_freed),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // allocator shadow state
  logic [ADDR_W-1:0] base_reg;
  logic [ADDR_W-1:0] top_reg;
  longint unsigned   area_base;
  longint unsigned   area_pages;
  int unsigned       free_top;
  bit                head_ok;
  int unsigned       link [NPAGES];
  bit                link_ok [NPAGES];
  int unsigned       refcnt [NPAGES];

  page_cmd_t    item_queue[$];
  page_result_t results_due[$];
  page_cmd_t    next_cmd;
  page_result_t want;

  int  items_sent = 0;
  int  items_taken = 0;
  int  results_checked = 0;
  int  mismatches = 0;
  int  cfg_writes = 0;
  int  pages_returned = 0;
  int  status_seen [8];
  int  quiet_cycles = 0;
  bit  no_idle = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void rebuild_tables();
    longint unsigned lo;
    longint unsigned hi;
    lo = base_reg & ~OFFSET_MASK;
    hi = top_reg & ~OFFSET_MASK;
    area_base  = lo;
    area_pages = (hi > lo) ? ((hi - lo) >> SHIFT) : 0;
    if (area_pages > NPAGES) area_pages = NPAGES;
    for (int i = 0; i < NPAGES; i++) begin
      refcnt[i] = 0;
      if (i > 0 && i < area_pages) begin
        link[i]    = i - 1;
        link_ok[i] = 1'b1;
      end else begin
        link[i]    = 0;
        link_ok[i] = 1'b0;
      end
    end
    head_ok  = area_pages > 0;
    free_top = head_ok ? int'(area_pages - 1) : 0;
  endfunction

  function automatic void return_page(int unsigned pg);
    link[pg]    = free_top;
    link_ok[pg] = head_ok;
    free_top    = pg;
    head_ok     = 1'b1;
  endfunction

  // advance the shadow state by one action and give the result it produces
  function automatic page_result_t page_action_result(logic [ACTION_W-1:0] act,
                                                      logic [ADDR_W-1:0] addr);
    page_result_t    r;
    longint unsigned a;
    int unsigned     pg;
    bit              hit;
    bit              aligned;
    r.alloc_address = '0;
    r.ref_count     = '0;
    r.page_freed    = 1'b0;
    r.status        = ST_OK;
    a       = addr;
    aligned = (addr & OFFSET_MASK) == '0;
    hit     = (a >= area_base) && (((a - area_base) >> SHIFT) < area_pages);
    pg      = hit ? int'((a - area_base) >> SHIFT) : 0;
    case (act)
      ACT_ALLOC: begin
        if (head_ok) begin
          pg       = free_top;
          free_top = link[pg];
          head_ok  = link_ok[pg];
          refcnt[pg] = 1;
          r.alloc_address = ADDR_W'(area_base + (longint'(pg) << SHIFT));
          r.ref_count     = 1;
        end else begin
          r.status = ST_EMPTY;
        end
      end
      ACT_FREE, ACT_INC, ACT_DEC, ACT_GET: begin
        if (!hit || (act == ACT_FREE && !aligned)) begin
          r.status = ST_BAD;
        end else begin
          case (act)
            ACT_FREE: begin
              return_page(pg);
              r.page_freed = 1'b1;
            end
            ACT_INC: begin
              if (refcnt[pg] >= CMAX) begin
                refcnt[pg] = CMAX;
                r.status = ST_SAT;
              end else begin
                refcnt[pg]++;
              end
            end
            ACT_DEC: begin
              if (refcnt[pg] == 0) begin
                r.status = ST_ZERO;
              end else begin
                refcnt[pg]--;
                // reaching zero returns the page only for an aligned address
                if (refcnt[pg] == 0) begin
                  if (aligned) begin
                    return_page(pg);
                    r.page_freed = 1'b1;
                  end else begin
                    r.status = ST_BAD;
                  end
                end
              end
            end
            default: ;
          endcase
          r.ref_count = COUNT_OUT_W'(refcnt[pg]);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {2'($urandom_range(0, 3)), $urandom};
  endfunction

  function automatic logic [ADDR_W-1:0] area_top(logic [ADDR_W-1:0] base, int pages);
    return (base & ~OFFSET_MASK) + (ADDR_W'(pages) << SHIFT)
           + ADDR_W'($urandom_range(0, (1 << SHIFT) - 1));
  endfunction

  // mostly pages near the free-list head, some boundary and wild addresses
  function automatic logic [ADDR_W-1:0] target_address();
    int r;
    int lo_pg;
    int pg;
    int off;
    r = $urandom_range(0, 99);
    if (r < 8 || area_pages == 0) return rand_addr();
    if (r < 14) return ADDR_W'(area_base - $urandom_range(1, 2 << SHIFT));
    if (r < 20) return ADDR_W'(area_base + (area_pages << SHIFT)
                               + $urandom_range(0, (2 << SHIFT) - 1));
    lo_pg = (area_pages > WINDOW) ? int'(area_pages) - WINDOW : 0;
    pg    = $urandom_range(lo_pg, int'(area_pages) - 1);
    off   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, (1 << SHIFT) - 1) : 0;
    return ADDR_W'(area_base + (longint'(pg) << SHIFT) + off);
  endfunction

  task automatic queue_item(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] addr);
    item_queue.push_back('{act, addr});
    items_sent++;
  endtask

  task automatic wait_drained();
    while (items_taken != items_sent || results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == REG_BASE) base_reg = value;
    else top_reg = value;
    rebuild_tables();
    cfg_writes++;
    // hold until the table sweep has run
    do @(posedge clk); while (busy !== 1'b1);
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic run_phase(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] top, int count,
                           bit calm);
    int r;
    logic [ACTION_W-1:0] act;
    write_register(REG_BASE, base);
    write_register(REG_TOP, top);
    no_idle = calm;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 25)      act = ACT_ALLOC;
      else if (r < 40) act = ACT_FREE;
      else if (r < 62) act = ACT_INC;
      else if (r < 84) act = ACT_DEC;
      else if (r < 95) act = ACT_GET;
      else             act = ACTION_W'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
      queue_item(act, target_address());
    end
    wait_drained();
    no_idle = 1'b0;
  endtask

  task automatic flag_mismatch(string what);
    if (mismatches < SHOW_LIMIT) $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // driver: hold the item while busy, advance on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        results_due.push_back(page_action_result(in_action, in_page_address));
        items_taken++;
      end
      if (!(start && busy)) begin
        if (item_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_cmd = item_queue.pop_front();
          start           <= 1'b1;
          in_action       <= next_cmd.action;
          in_page_address <= next_cmd.addr;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (results_due.size() == 0) begin
        flag_mismatch("result with no item outstanding");
      end else begin
        want = results_due.pop_front();
        if (out_alloc_address !== want.alloc_address)
          flag_mismatch($sformatf("alloc_address %h, expected %h",
                                  out_alloc_address, want.alloc_address));
        if (out_ref_count !== want.ref_count)
          flag_mismatch($sformatf("ref_count %0d, expected %0d",
                                  out_ref_count, want.ref_count));
        if (out_page_freed !== want.page_freed)
          flag_mismatch($sformatf("page_freed %b, expected %b",
                                  out_page_freed, want.page_freed));
        if (out_status !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d (%s)",
                                  out_status, want.status, want.status.name()));
        results_checked++;
        status_seen[int'(want.status)]++;
        if (want.page_freed) pages_returned++;
      end
    end
  end

  // watchdog: table sweeps are the longest quiet stretches
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1 || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no traffic for %0d cycles, %0d results outstanding",
               quiet_cycles, results_due.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi_pg;
    logic [ADDR_W-1:0] b;
    base_reg = BASE_RESET;
    top_reg  = TOP_RESET;
    rebuild_tables();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed items on the reset layout
    lo    = ADDR_W'(area_base);
    hi_pg = ADDR_W'(area_base + ((area_pages - 1) << SHIFT));
    queue_item(ACT_GET, lo);
    queue_item(ACT_ALLOC, '0);
    queue_item(ACT_INC, hi_pg);
    queue_item(ACT_GET, hi_pg + 34'h123);
    queue_item(ACT_DEC, hi_pg);
    queue_item(ACT_DEC, hi_pg + 34'h7FF);          // to zero, unaligned: no push
    queue_item(ACT_DEC, hi_pg);                    // already zero
    queue_item(ACT_FREE, hi_pg + 34'h10);          // misaligned free
    queue_item(ACT_FREE, hi_pg);
    queue_item(ACT_ALLOC, '0);
    queue_item(ACT_DEC, hi_pg);                    // to zero, returns the page
    queue_item(ACT_INC, lo - 34'd1);
    queue_item(ACT_GET, hi_pg + (34'd1 << SHIFT)); // first address past the area
    queue_item(ACT_INC, '0);
    queue_item(ACT_GET, '1);
    for (int a = ACT_RSVD_LO; a <= ACT_RSVD_HI; a++) queue_item(ACTION_W'(a), rand_addr());
    queue_item(ACT_FREE, lo);
    queue_item(ACT_INC, lo);
    queue_item(ACT_DEC, lo);
    // raise one count a few times and bring it back down one
    for (int i = 0; i < 4; i++) queue_item(ACT_INC, lo + (34'd1 << SHIFT));
    queue_item(ACT_GET, lo + (34'd1 << SHIFT));
    queue_item(ACT_DEC, lo + (34'd1 << SHIFT));
    wait_drained();

    run_phase('0, '1, 320, 1'b0);                      // full table, clamped
    b = rand_addr();
    run_phase(b, area_top(b, 24), 320, 1'b1);          // no idling here
    run_phase(34'h3_FFFF_E5A5, '1, 180, 1'b0);         // single page at the top
    run_phase(34'h1_0000_0000, 34'h0_8000_0000, 90, 1'b0); // inverted bounds
    b = rand_addr();
    run_phase(b, area_top(b, $urandom_range(2, 6)), 360, 1'b0);
    b = rand_addr();
    run_phase(b, area_top(b, $urandom_range(8, 40)), 360, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d results from %0d actions across %0d register writes",
             results_checked, items_taken, cfg_writes);
    $display("Outcomes: ok %0d, empty %0d, bad address %0d, zero %0d, saturated %0d, freed %0d",
             status_seen[int'(ST_OK)], status_seen[int'(ST_EMPTY)], status_seen[int'(ST_BAD)],
             status_seen[int'(ST_ZERO)], status_seen[int'(ST_SAT)], pages_returned);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
